### rtl/wgm_pkg.sv
// Package for the wildcard glob matcher.
// Holds request codes, controller states, command/status structs and the case fold.
// No dependencies.
package wgm_pkg;

   localparam int unsigned MAX_PATTERN_DEF = 64;
   localparam logic [7:0]  SINGLE_WILD_RST = 8'd63;
   localparam logic [7:0]  MULTI_WILD_RST  = 8'd42;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_CHAR   = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   typedef enum logic {
      CSR_SINGLE_WILD = 1'b0,
      CSR_MULTI_WILD  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRIME,
      ST_SWEEP,
      ST_EMIT
   } ctl_state_type;

   typedef struct packed {
      logic accept;
      logic prime;
      logic sweep;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last_step;
      logic is_end;
   } status_type;

   // upper-case fold of ASCII letters
   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c inside {[8'h61:8'h7a]}) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

### rtl/wgm_ctrl.sv
// Controller of the wildcard glob matcher: request handshake, sweep sequencing,
// response register handshake. Depends on wgm_pkg.
module wgm_ctrl
   import wgm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  action_type req_action,
   input  status_type status,
   output cmd_type    cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_action == ACT_CHAR || req_action == ACT_END) begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.last_step) begin
               state_in = status.is_end ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

endmodule

### rtl/wgm_datapath.sv
// Datapath of the wildcard glob matcher: pattern memory, live position shift
// register, wildcard registers, sweep cell and response register. Depends on wgm_pkg.
module wgm_datapath
   import wgm_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  action_type req_action,
   input  logic [7:0] req_char,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output logic       rsp_matched,
   output logic       rsp_overflow
);

   localparam int unsigned AW = $clog2(MAX_PATTERN);
   localparam int unsigned PW = $clog2(MAX_PATTERN + 1);
   localparam int unsigned NP = MAX_PATTERN + 1;

   logic [7:0]    store [MAX_PATTERN];
   logic [7:0]    rd_data_ff;
   logic [AW-1:0] rd_addr;

   logic [PW-1:0] len_ff, len_in;
   logic          ovf_ff, ovf_in;
   logic [NP-1:0] live_ff, live_in;
   logic [7:0]    single_ff, multi_ff;
   logic [PW-1:0] pos_ff, pos_in, pos_next;
   logic          carry_ff, carry_in;
   logic          pend_ff, pend_in;
   logic          hit_ff, hit_in;
   logic          is_end_ff;
   logic [7:0]    char_ff;
   logic          matched_ff, overflow_ff;

   logic          do_write;
   logic          cur, active, is_star, is_match, nxt_bit;

   // pattern memory
   assign do_write = cmd.accept && (req_action == ACT_APPEND) &&
                     (len_ff < PW'(MAX_PATTERN));
   assign pos_next = pos_ff + 1'b1;
   assign rd_addr  = cmd.sweep ? pos_next[AW-1:0] : '0;

   always_ff @(posedge clock) begin
      if (do_write) begin
         store[len_ff[AW-1:0]] <= req_char;
      end
      rd_data_ff <= store[rd_addr];
   end

   // sweep cell for position pos_ff
   assign cur      = live_ff[0] | carry_ff;
   assign active   = pos_ff < len_ff;
   assign is_star  = active && (rd_data_ff == multi_ff);
   assign is_match = active && !is_star &&
                     ((rd_data_ff == single_ff) || (fold(rd_data_ff) == fold(char_ff)));
   assign nxt_bit  = pend_ff | (cur & is_star);

   always_comb begin
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      live_in  = live_ff;
      pos_in   = pos_ff;
      carry_in = carry_ff;
      pend_in  = pend_ff;
      hit_in   = hit_ff;
      if (cmd.accept && req_action == ACT_CLEAR) begin
         len_in  = '0;
         ovf_in  = 1'b0;
         live_in = NP'(1);
      end
      if (cmd.accept && req_action == ACT_APPEND) begin
         if (do_write) begin
            len_in = len_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (cmd.prime) begin
         pos_in   = '0;
         carry_in = 1'b0;
         pend_in  = 1'b0;
         hit_in   = 1'b0;
      end
      if (cmd.sweep) begin
         pos_in   = pos_next;
         carry_in = cur & is_star;
         pend_in  = cur & is_match;
         live_in  = {nxt_bit, live_ff[NP-1:1]};
         if (pos_ff == len_ff) begin
            hit_in = cur;
         end
      end
      if (cmd.load_rsp) begin
         live_in = NP'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         live_ff   <= NP'(1);
         single_ff <= SINGLE_WILD_RST;
         multi_ff  <= MULTI_WILD_RST;
      end else begin
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         live_ff <= live_in;
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_SINGLE_WILD: single_ff <= csr_wdata;
               CSR_MULTI_WILD:  multi_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      carry_ff <= carry_in;
      pend_ff  <= pend_in;
      hit_ff   <= hit_in;
      if (cmd.accept) begin
         char_ff   <= req_char;
         is_end_ff <= (req_action == ACT_END);
      end
      if (cmd.load_rsp) begin
         matched_ff  <= hit_ff & ~ovf_ff;
         overflow_ff <= ovf_ff;
      end
   end

   assign status.last_step = (pos_ff == PW'(MAX_PATTERN));
   assign status.is_end    = is_end_ff;
   assign rsp_matched      = matched_ff;
   assign rsp_overflow     = overflow_ff;

endmodule

### rtl/wildcard_glob_matcher.sv
// Wildcard glob matcher top level: stream request/response ports and write-only
// register port around controller and datapath. Depends on wgm_pkg, wgm_ctrl,
// wgm_datapath.
//
// Load a pattern with append requests (clear first), then stream string
// characters and finish each string with an end-of-string request, which
// returns one response with the match and overflow flags and re-arms for the
// next string. Letters compare case-insensitively; the single and multi
// wildcard codes are registers 0 and 1 (defaults '?' and '*'). Each string
// character and end-of-string walks all MAX_PATTERN + 1 pattern positions
// through the single read port of the pattern memory, one position a cycle,
// and an end-of-string then waits until the previous response is taken.
// Appends beyond MAX_PATTERN are dropped and flag overflow until the next clear.
module wildcard_glob_matcher
   import wgm_pkg::*;
#(
   parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] matched, [1] overflow, [7:2] zero
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;
   action_type req_action;
   logic       rsp_matched, rsp_overflow;

   assign req_action = action_type'(req_tuser);

   wgm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .req_action (req_action),
      .status     (status),
      .cmd        (cmd)
   );

   wgm_datapath #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_action   (req_action),
      .req_char     (req_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_matched  (rsp_matched),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = {6'b0, rsp_overflow, rsp_matched};

`ifndef NO_ASSERTIONS
   a_no_sweep_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.sweep && !cmd.prime)
      else $error("request accepted during a sweep");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_tvalid)
      else $error("response load without valid");

   a_match_excludes_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[1])
      else $error("match reported on an overflowed pattern");
`endif

endmodule

### test/wildcard_glob_matcher_tb.sv
// Self-checking testbench for wildcard_glob_matcher: streams pattern, string and end requests,
// predicts each match verdict in a local live-position tracker and checks every response.
// Depends on wgm_pkg and the wildcard_glob_matcher RTL.
`timescale 1ns / 100ps

module wildcard_glob_matcher_tb;
   import wgm_pkg::*;

   localparam int MAXP = MAX_PATTERN_DEF;
   localparam int HOLDOFF_CYCLES = 600;

   typedef struct packed {
      action_type act;
      logic [7:0] code;
   } glob_request_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;    // [7:0] char_code
   logic [1:0] req_tuser = ACT_CLEAR; // [1:0] action
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [0] matched, [1] overflow, [7:2] zero
   logic       csr_wr_en = 1'b0;
   logic       csr_index = CSR_SINGLE_WILD;
   logic [7:0] csr_wdata = 8'h00;

   glob_request_type req_items[$];
   verdict_type      verdicts_due[$];
   glob_request_type next_req;
   verdict_type      want;

   logic [7:0]    pat_mem [MAXP];
   int            pat_len = 0;
   logic          pat_ovf = 1'b0;
   logic [MAXP:0] live_set = (MAXP + 1)'(1);
   logic [7:0]    exp_single = SINGLE_WILD_RST;
   logic [7:0]    exp_multi = MULTI_WILD_RST;

   int items_queued = 0;
   int fail_count = 0;
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   int holdoff_trigger = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;

   logic [7:0] single_set [6] = '{8'd63, 8'd0, 8'd95, 8'd42, 8'd255, 8'd63};
   logic [7:0] multi_set [6] = '{8'd42, 8'd255, 8'd37, 8'd42, 8'd0, 8'd42};
   int         tx_set [6] = '{0, 51, 0, 37, 0, 20};
   int         rx_set [6] = '{0, 0, 51, 37, 0, 20};

   wildcard_glob_matcher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] upcase(input logic [7:0] c);
      if (c >= 8'h61 && c <= 8'h7a) begin
         return c - 8'h20;
      end
      return c;
   endfunction

   function automatic logic [MAXP:0] closed_live();
      logic [MAXP:0] s;
      s = live_set;
      for (int i = 0; i < MAXP; i++) begin
         if (i < pat_len && s[i] && pat_mem[i] == exp_multi) begin
            s[i + 1] = 1'b1;
         end
      end
      return s;
   endfunction

   function automatic void advance_matcher(input action_type act, input logic [7:0] ch);
      logic [MAXP:0] cur;
      logic [MAXP:0] nxt;
      case (act)
         ACT_CLEAR: begin
            pat_len = 0;
            pat_ovf = 1'b0;
            live_set = (MAXP + 1)'(1);
         end
         ACT_APPEND: begin
            if (pat_len < MAXP) begin
               pat_mem[pat_len] = ch;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         ACT_CHAR: begin
            cur = closed_live();
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (cur[i]) begin
                  if (pat_mem[i] == exp_multi) begin
                     nxt[i] = 1'b1;
                  end else if (pat_mem[i] == exp_single || upcase(pat_mem[i]) == upcase(ch)) begin
                     nxt[i + 1] = 1'b1;
                  end
               end
            end
            live_set = nxt;
         end
         default: begin
            cur = closed_live();
            verdicts_due.push_back('{cur[pat_len] && !pat_ovf, pat_ovf});
            live_set = (MAXP + 1)'(1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_matcher(action_type'(req_tuser), req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (req_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               next_req = req_items.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= next_req.act;
               req_tdata <= next_req.code;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left != 0) begin
         rsp_tready <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_trigger != holdoff_seen) begin
         holdoff_seen <= holdoff_trigger;
         holdoff_left <= HOLDOFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdicts_due.size() == 0) begin
            $error("unexpected response: rsp_tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_tdata[0] !== want.matched) begin
               $error("matched: expected %0d, actual %0d", want.matched, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[1] !== want.overflow) begin
               $error("overflow: expected %0d, actual %0d", want.overflow, rsp_tdata[1]);
               fail_count++;
            end
         end
      end
   end

   function automatic void queue_request(input action_type a, input logic [7:0] c);
      req_items.push_back('{a, c});
      items_queued++;
   endfunction

   function automatic logic [7:0] any_code();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] letter_code();
      return 8'((8'h61 + $urandom_range(2)) ^ ($urandom_range(1) << 5));
   endfunction

   function automatic logic [7:0] text_char();
      if ($urandom_range(7) == 0) begin
         return any_code();
      end
      return letter_code();
   endfunction

   function automatic logic [7:0] pattern_char();
      int r;
      r = $urandom_range(19);
      if (r < 4) begin
         return exp_multi;
      end else if (r < 7) begin
         return exp_single;
      end else if (r < 18) begin
         return letter_code();
      end
      return any_code();
   endfunction

   function automatic logic [7:0] flip_case(input logic [7:0] p);
      if (((p >= 8'h61 && p <= 8'h7a) || (p >= 8'h41 && p <= 8'h5a)) && $urandom_range(1)) begin
         return p ^ 8'h20;
      end
      return p;
   endfunction

   task automatic make_text(input logic [7:0] pat[$], output logic [7:0] text[$]);
      int n;
      int idx;
      text = {};
      if ($urandom_range(9) < 6) begin
         foreach (pat[i]) begin
            if (pat[i] == exp_multi) begin
               n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
               repeat (n) text.push_back(text_char());
            end else if (pat[i] == exp_single) begin
               text.push_back(text_char());
            end else begin
               text.push_back(flip_case(pat[i]));
            end
         end
         if ($urandom_range(2) == 0) begin
            idx = (text.size() == 0) ? 0 : $urandom_range(text.size() - 1);
            case ($urandom_range(2))
               0: if (text.size() != 0) text[idx] = text_char();
               1: text.insert(idx, text_char());
               default: if (text.size() != 0) text.delete(idx);
            endcase
         end
      end else begin
         repeat ($urandom_range(5)) text.push_back(text_char());
      end
   endtask

   task automatic push_session(input bit full);
      logic [7:0] pat[$];
      logic [7:0] text[$];
      logic [7:0] c;
      int len;
      queue_request(ACT_CLEAR, any_code());
      len = full ? MAXP - 1 + $urandom_range(3) : $urandom_range(6);
      for (int i = 0; i < len; i++) begin
         c = (full && $urandom_range(4) != 0) ? exp_multi : pattern_char();
         if (pat.size() < MAXP) pat.push_back(c);
         queue_request(ACT_APPEND, c);
      end
      repeat (full ? 1 : $urandom_range(1, 3)) begin
         make_text(pat, text);
         foreach (text[k]) begin
            if ($urandom_range(49) == 0) begin
               c = pattern_char();
               if (pat.size() < MAXP) pat.push_back(c);
               queue_request(ACT_APPEND, c);
            end else if ($urandom_range(49) == 0) begin
               queue_request(action_type'($urandom_range(3)), any_code());
            end
            queue_request(ACT_CHAR, text[k]);
         end
         queue_request(ACT_END, any_code());
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (req_items.size() != 0 || req_tvalid || verdicts_due.size() != 0);
      repeat (MAXP + 8) @(negedge clock);
   endtask

   task automatic set_wildcards(input logic [7:0] single_code, input logic [7:0] multi_code);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SINGLE_WILD;
      csr_wdata <= single_code;
      exp_single <= single_code;
      @(posedge clock);
      csr_index <= CSR_MULTI_WILD;
      csr_wdata <= multi_code;
      exp_multi <= multi_code;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_request(ACT_END, any_code());
      queue_request(ACT_APPEND, 8'h61);
      queue_request(ACT_APPEND, 8'h3f);
      queue_request(ACT_APPEND, 8'h2a);
      queue_request(ACT_APPEND, 8'h7a);
      queue_request(ACT_CHAR, 8'h41);
      queue_request(ACT_CHAR, 8'hff);
      queue_request(ACT_CHAR, 8'h71);
      queue_request(ACT_CHAR, 8'h5a);
      queue_request(ACT_END, any_code());
      queue_request(ACT_CHAR, 8'h61);
      queue_request(ACT_CHAR, 8'h00);
      queue_request(ACT_APPEND, 8'h78);
      queue_request(ACT_CHAR, 8'h7a);
      queue_request(ACT_CHAR, 8'h58);
      queue_request(ACT_END, any_code());
      queue_request(ACT_CLEAR, any_code());
      queue_request(ACT_APPEND, 8'h00);
      queue_request(ACT_APPEND, 8'hff);
      queue_request(ACT_APPEND, 8'he9);
      queue_request(ACT_CHAR, 8'h00);
      queue_request(ACT_CHAR, 8'hff);
      queue_request(ACT_CHAR, 8'hc9);
      queue_request(ACT_END, any_code());

      for (int ph = 0; ph < 6; ph++) begin
         if (ph != 0) begin
            settle();
            set_wildcards(single_set[ph], multi_set[ph]);
            @(negedge clock);
            queue_request(ACT_CHAR, text_char());
            queue_request(ACT_END, any_code());
         end
         tx_idle_pct = tx_set[ph];
         rx_stall_pct = rx_set[ph];
         if (ph == 4) begin
            holdoff_trigger++;
            repeat (12) queue_request(ACT_END, any_code());
         end
         if (ph == 0 || ph == 4) push_session(1'b1);
         while (items_queued < (ph + 1) * 118) push_session(1'b0);
         if (ph < 5) begin
            repeat (2) queue_request(ACT_CHAR, text_char());
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("wildcard_glob_matcher_tb passed");
      end else begin
         $display("wildcard_glob_matcher_tb failed");
      end
      $finish;
   end

   initial begin
      #1500000;
      $display("wildcard_glob_matcher_tb failed");
      $finish;
   end

endmodule

### wildcard_glob_matcher.f
rtl/wgm_pkg.sv
rtl/wgm_ctrl.sv
rtl/wgm_datapath.sv
rtl/wildcard_glob_matcher.sv
test/wildcard_glob_matcher_tb.sv
